// ===== sv/rdsc_pkg.sv =====
// shared constants, types and register codes for the ramped drive soft clipper
`default_nettype none
package rdsc_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int DRV_W          = 22;
  localparam int MKP_W          = 17;
  localparam int STEPS_W        = 10;
  localparam int MAG_W          = 26;
  localparam int MUL_A_W        = 27;
  localparam int MUL_B_W        = 26;
  localparam int PROD_W         = 53;
  localparam int DIV_W          = 26;
  localparam int ITER_W         = 5;
  localparam int NUM_W          = 50;
  localparam int ADDR_W         = 4;
  localparam int DATA_W         = 32;

  localparam int Q_FRAC   = 24;
  localparam int X_SHIFT  = SAMPLE_BITS - 1 + GAIN_FRAC_BITS - Q_FRAC;
  localparam int SQ_SHIFT = 26;
  localparam int O_SHIFT  = 25 + GAIN_FRAC_BITS - SAMPLE_BITS;

  localparam logic signed [PROD_W-1:0] X_RND     = PROD_W'(1) << (X_SHIFT - 1);
  localparam logic signed [PROD_W-1:0] SQ_RND    = PROD_W'(1) << (SQ_SHIFT - 1);
  localparam logic signed [PROD_W-1:0] O_RND     = PROD_W'(1) << (O_SHIFT - 1);
  localparam logic signed [PROD_W-1:0] CLAMP_POS = PROD_W'(2) << Q_FRAC;
  localparam logic signed [PROD_W-1:0] CLAMP_NEG = -CLAMP_POS;
  localparam logic signed [PROD_W-1:0] SMAX      = (PROD_W'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [PROD_W-1:0] SMIN      = -SMAX - 1;
  localparam logic [MAG_W-1:0]         MAG_LIM   = MAG_W'(2) << Q_FRAC;
  localparam logic [DIV_W-1:0]         Q24_ONE   = DIV_W'(1) << Q_FRAC;

  localparam logic [ITER_W-1:0] DRV_ITERS = ITER_W'(DRV_W);
  localparam logic [ITER_W-1:0] MKP_ITERS = ITER_W'(MKP_W);
  localparam logic [ITER_W-1:0] SHP_ITERS = ITER_W'(DIV_W);

  localparam logic [DRV_W-1:0]   RST_IN_GAIN  = DRV_W'(65536);
  localparam logic [MKP_W-1:0]   RST_OUT_GAIN = MKP_W'(65536);
  localparam logic [STEPS_W-1:0] RST_STEPS    = STEPS_W'(240);

  typedef enum logic [1:0] {
    REG_ENABLE   = 2'd0,
    REG_IN_GAIN  = 2'd1,
    REG_OUT_GAIN = 2'd2,
    REG_STEPS    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
  } div_ctl_t;

endpackage
`default_nettype wire

// ===== sv/rdsc_mul.sv =====
// shared signed by unsigned multiplier with registered product
`default_nettype none
module rdsc_mul
  import rdsc_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic        [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]  prod_r
);

  logic signed [PROD_W-1:0] prod_nxt;

  assign prod_nxt = a * $signed({1'b0, b});

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/rdsc_div.sv =====
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module rdsc_div
  import rdsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl,
  input  logic [DIV_W-1:0] rem_init,
  input  logic [DIV_W-1:0] num_lo,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic [DIV_W-1:0] quot
);

  logic              busy_r;
  logic [ITER_W-1:0] cnt_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  num_r;
  logic [DIV_W-1:0]  dvs_r;
  logic [DIV_W-1:0]  quot_r;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;

  assign trial = {rem_r, num_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign busy  = busy_r;
  assign quot  = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl.start) begin
      busy_r <= (ctl.iters != '0);
      cnt_r  <= ctl.iters;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == ITER_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r  <= rem_init;
      num_r  <= num_lo;
      dvs_r  <= divisor;
      quot_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_W-2:0], 1'b0};
      if (!diff[DIV_W]) begin
        rem_r  <= diff[DIV_W-1:0];
        quot_r <= {quot_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r  <= trial[DIV_W-1:0];
        quot_r <= {quot_r[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/ramped_drive_soft_clipper.sv =====
// top level: registers, gain ramps and sequencer around the shared multiplier and divider
//
//   channel   direction  handshake                 payload
//   in_       request    in_valid / in_ready       in_sample_in   [23:0] signed
//   out_      result     out_valid / out_ready     out_sample_out [23:0] signed
//   config    apb write  psel, penable, pwrite     paddr [3:0], pwdata [31:0]
//
// disabled item: S_OUT follows accept, loads the result register when free, then goes idle
// enabled item: S_RTD through S_RND run before S_OUT loads the result; shaper divide is S_DVS
// a ramp start adds a divide per gain: S_DVD for drive, S_DVM for makeup
// in_ready is high only in idle; the result register lets the next request in while it waits
// rst_n is synchronous; it restores register defaults and ramp state
`default_nettype none
module ramped_drive_soft_clipper
  import rdsc_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready
);

  typedef enum logic [14:0] {
    S_IDLE = 15'h0001,
    S_RTD  = 15'h0002,
    S_DVD  = 15'h0004,
    S_RTM  = 15'h0008,
    S_DVM  = 15'h0010,
    S_ADV  = 15'h0020,
    S_M1   = 15'h0040,
    S_CLP  = 15'h0080,
    S_SQ   = 15'h0100,
    S_DEN  = 15'h0200,
    S_DST  = 15'h0400,
    S_DVS  = 15'h0800,
    S_M3   = 15'h1000,
    S_RND  = 15'h2000,
    S_OUT  = 15'h4000
  } state_t;

  state_t state_r, state_nxt;

  logic               enable_r;
  logic [DRV_W-1:0]   in_gain_r;
  logic [MKP_W-1:0]   out_gain_r;
  logic [STEPS_W-1:0] steps_r;

  logic [DRV_W-1:0]        drv_now_r, drv_tgt_r;
  logic signed [DRV_W:0]   drv_step_r;
  logic [STEPS_W-1:0]      drv_left_r;
  logic [MKP_W-1:0]        mkp_now_r, mkp_tgt_r;
  logic signed [MKP_W:0]   mkp_step_r;
  logic [STEPS_W-1:0]      mkp_left_r;

  logic signed [SAMPLE_BITS-1:0] smp_r, res_r, out_sample_r;
  logic                          out_valid_r;
  logic                          neg_r;
  logic [MAG_W-1:0]              mag_r;
  logic [DIV_W-1:0]              den_r;
  logic signed [DIV_W-1:0]       y_r;

  logic                      wr_en;
  reg_idx_t                  wr_idx;
  logic                      in_acc;
  logic                      out_free;

  logic signed [DRV_W:0]     drv_diff, drv_q, drv_sum;
  logic [DRV_W-1:0]          drv_mag;
  logic signed [MKP_W:0]     mkp_diff, mkp_q, mkp_sum;
  logic [MKP_W-1:0]          mkp_mag;

  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [PROD_W-1:0]  prod_r;

  div_ctl_t                  div_ctl;
  logic [DIV_W-1:0]          div_rem, div_num, div_dvs, div_quot;
  logic                      div_busy;

  logic signed [PROD_W-1:0]  x_full, sq_rnd, o_full;
  logic [NUM_W-1:0]          shp_num;
  logic signed [DIV_W-1:0]   y_q;

  assign pready   = 1'b1;
  assign wr_en    = psel & penable & pwrite;
  assign wr_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  always_comb begin
    case (wr_idx)
      REG_ENABLE:   prdata = DATA_W'(enable_r);
      REG_IN_GAIN:  prdata = DATA_W'(in_gain_r);
      REG_OUT_GAIN: prdata = DATA_W'(out_gain_r);
      REG_STEPS:    prdata = DATA_W'(steps_r);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      in_gain_r  <= RST_IN_GAIN;
      out_gain_r <= RST_OUT_GAIN;
      steps_r    <= RST_STEPS;
    end else if (wr_en) begin
      case (wr_idx)
        REG_ENABLE:   enable_r   <= pwdata[0];
        REG_IN_GAIN:  in_gain_r  <= pwdata[DRV_W-1:0];
        REG_OUT_GAIN: out_gain_r <= pwdata[MKP_W-1:0];
        REG_STEPS:    steps_r    <= pwdata[STEPS_W-1:0];
        default:      enable_r   <= enable_r;
      endcase
    end
  end

  // ramp arithmetic
  assign drv_diff = $signed({1'b0, in_gain_r}) - $signed({1'b0, drv_now_r});
  assign drv_mag  = drv_diff[DRV_W] ? DRV_W'(-drv_diff) : drv_diff[DRV_W-1:0];
  assign drv_q    = $signed({1'b0, div_quot[DRV_W-1:0]});
  assign drv_sum  = $signed({1'b0, drv_now_r}) + drv_step_r;
  assign mkp_diff = $signed({1'b0, out_gain_r}) - $signed({1'b0, mkp_now_r});
  assign mkp_mag  = mkp_diff[MKP_W] ? MKP_W'(-mkp_diff) : mkp_diff[MKP_W-1:0];
  assign mkp_q    = $signed({1'b0, div_quot[MKP_W-1:0]});
  assign mkp_sum  = $signed({1'b0, mkp_now_r}) + mkp_step_r;

  // shaper arithmetic
  assign x_full  = (prod_r + X_RND) >>> X_SHIFT;
  assign sq_rnd  = prod_r + SQ_RND;
  assign shp_num = {mag_r, {Q_FRAC{1'b0}}} + NUM_W'(den_r[DIV_W-1:1]);
  assign y_q     = $signed(div_quot);
  assign o_full  = (prod_r + O_RND) >>> O_SHIFT;

  always_comb begin
    case (state_r)
      S_M1: begin
        mul_a = MUL_A_W'(smp_r);
        mul_b = MUL_B_W'(drv_now_r);
      end
      S_SQ: begin
        mul_a = $signed({1'b0, mag_r});
        mul_b = mag_r;
      end
      S_M3: begin
        mul_a = MUL_A_W'(y_r);
        mul_b = MUL_B_W'(mkp_now_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.iters = DRV_ITERS;
    div_rem       = '0;
    div_num       = {drv_mag, {(DIV_W-DRV_W){1'b0}}};
    div_dvs       = DIV_W'(steps_r);
    case (state_r)
      S_RTD: begin
        div_ctl.start = (in_gain_r != drv_tgt_r) && (steps_r != '0);
      end
      S_RTM: begin
        div_ctl.start = (out_gain_r != mkp_tgt_r) && (steps_r != '0);
        div_ctl.iters = MKP_ITERS;
        div_num       = {mkp_mag, {(DIV_W-MKP_W){1'b0}}};
      end
      S_DST: begin
        div_ctl.start = 1'b1;
        div_ctl.iters = SHP_ITERS;
        div_rem       = DIV_W'(shp_num[NUM_W-1:DIV_W]);
        div_num       = shp_num[DIV_W-1:0];
        div_dvs       = den_r;
      end
      default: div_ctl.start = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = enable_r ? S_RTD : S_OUT;
      S_RTD:  state_nxt = div_ctl.start ? S_DVD : S_RTM;
      S_DVD:  if (!div_busy) state_nxt = S_RTM;
      S_RTM:  state_nxt = div_ctl.start ? S_DVM : S_ADV;
      S_DVM:  if (!div_busy) state_nxt = S_ADV;
      S_ADV:  state_nxt = S_M1;
      S_M1:   state_nxt = S_CLP;
      S_CLP:  state_nxt = S_SQ;
      S_SQ:   state_nxt = S_DEN;
      S_DEN:  state_nxt = S_DST;
      S_DST:  state_nxt = S_DVS;
      S_DVS:  if (!div_busy) state_nxt = S_M3;
      S_M3:   state_nxt = S_RND;
      S_RND:  state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // gain ramps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drv_now_r  <= RST_IN_GAIN;
      drv_tgt_r  <= RST_IN_GAIN;
      drv_step_r <= '0;
      drv_left_r <= '0;
      mkp_now_r  <= RST_OUT_GAIN;
      mkp_tgt_r  <= RST_OUT_GAIN;
      mkp_step_r <= '0;
      mkp_left_r <= '0;
    end else begin
      case (state_r)
        S_RTD: begin
          if (in_gain_r != drv_tgt_r) begin
            drv_tgt_r <= in_gain_r;
            if (steps_r == '0) begin
              drv_now_r  <= in_gain_r;
              drv_left_r <= '0;
              drv_step_r <= '0;
            end else begin
              drv_left_r <= steps_r;
            end
          end
        end
        S_DVD: begin
          if (!div_busy) drv_step_r <= drv_diff[DRV_W] ? -drv_q : drv_q;
        end
        S_RTM: begin
          if (out_gain_r != mkp_tgt_r) begin
            mkp_tgt_r <= out_gain_r;
            if (steps_r == '0) begin
              mkp_now_r  <= out_gain_r;
              mkp_left_r <= '0;
              mkp_step_r <= '0;
            end else begin
              mkp_left_r <= steps_r;
            end
          end
        end
        S_DVM: begin
          if (!div_busy) mkp_step_r <= mkp_diff[MKP_W] ? -mkp_q : mkp_q;
        end
        S_ADV: begin
          if (drv_left_r != '0) begin
            drv_left_r <= drv_left_r - 1'b1;
            drv_now_r  <= (drv_left_r == STEPS_W'(1)) ? drv_tgt_r : drv_sum[DRV_W-1:0];
          end
          if (mkp_left_r != '0) begin
            mkp_left_r <= mkp_left_r - 1'b1;
            mkp_now_r  <= (mkp_left_r == STEPS_W'(1)) ? mkp_tgt_r : mkp_sum[MKP_W-1:0];
          end
        end
        default: drv_now_r <= drv_now_r;
      endcase
    end
  end

  // sample datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          smp_r <= in_sample_in;
          res_r <= in_sample_in;
        end
      end
      S_CLP: begin
        if (x_full > CLAMP_POS) begin
          neg_r <= 1'b0;
          mag_r <= MAG_LIM;
        end else if (x_full < CLAMP_NEG) begin
          neg_r <= 1'b1;
          mag_r <= MAG_LIM;
        end else if (x_full[PROD_W-1]) begin
          neg_r <= 1'b1;
          mag_r <= MAG_W'(-x_full);
        end else begin
          neg_r <= 1'b0;
          mag_r <= x_full[MAG_W-1:0];
        end
      end
      S_DEN: den_r <= Q24_ONE + DIV_W'(sq_rnd >>> SQ_SHIFT);
      S_DVS: if (!div_busy) y_r <= neg_r ? -y_q : y_q;
      S_RND: begin
        if (o_full > SMAX) begin
          res_r <= SMAX[SAMPLE_BITS-1:0];
        end else if (o_full < SMIN) begin
          res_r <= SMIN[SAMPLE_BITS-1:0];
        end else begin
          res_r <= o_full[SAMPLE_BITS-1:0];
        end
      end
      S_OUT: if (out_free) out_sample_r <= res_r;
      default: smp_r <= smp_r;
    endcase
  end

  rdsc_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  rdsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .rem_init (div_rem),
    .num_lo   (div_num),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quot     (div_quot)
  );

  a_bypass_direct: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !enable_r) |=> state_r == S_OUT)
    else $error("bypass request did not go straight to output");

  a_ramp_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADV && drv_left_r == STEPS_W'(1)) |=> drv_now_r == drv_tgt_r)
    else $error("drive ramp missed its target on the last step");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_busy)
    else $error("divider started while busy");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside output state");

endmodule
`default_nettype wire
